FILE: rtl/scsr_pkg.sv
// Shared types, codes and fixed port widths of the compressed-row adjacency store.
package scsr_pkg;

   localparam int OP_W   = 3;
   localparam int VTX_W  = 7;
   localparam int STS_W  = 2;
   localparam int CNT_W  = 6;
   localparam int CFG_W  = 8;
   localparam int CSR_DW = 32;
   localparam int CSR_AW = 3;

   // a listing streams at most this many beats
   localparam int RESULT_LIMIT = 32;

   // register select: paddr bit 2 and up
   localparam logic [CSR_AW-3:0] REG_IVC = '0;

   typedef enum logic [OP_W-1:0] {
      OP_ADD     = 3'd0,
      OP_DELETE  = 3'd1,
      OP_TEST    = 3'd2,
      OP_DEGREE  = 3'd3,
      OP_LIST    = 3'd4,
      OP_CLEAR   = 3'd5,
      OP_REMOVE  = 3'd6,
      OP_REBUILD = 3'd7
   } op_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK    = 2'd0,
      STS_MISS  = 2'd1,
      STS_FULL  = 2'd2,
      STS_RANGE = 2'd3
   } sts_type;

   typedef struct packed {
      logic             done_ok;
      sts_type          status;
      logic [CNT_W-1:0] neighbor_count;
      logic [VTX_W-1:0] neighbor;
      logic             list_empty;
      logic             last;
   } rsp_type;

   // single closing beat with no count or neighbour
   function automatic rsp_type mk_rsp(logic ok, sts_type st);
      rsp_type r;
      r                = '0;
      r.done_ok        = ok;
      r.status         = st;
      r.last           = 1'b1;
      return r;
   endfunction

endpackage

FILE: rtl/sorted_csr_adjacency_store.sv
// Undirected graph store in compressed-row form, walked by one memory sequencer.
// Work: add and delete move the entries behind the edit and shift the row starts;
//   clear repeats a delete per neighbour, remove of a lower vertex walks every row and
//   rotates the highest row's block into its slot; rebuild sweeps MAX_VERTICES+1 row starts.
// Throughput: one request at a time; a new one is taken only when the sequencer is idle.
// Reset: synchronous, active high; vertex count and register go to zero, and the
//   row-start memory is cleared by the rebuild sweep before any row is read.
module sorted_csr_adjacency_store #(
   parameter int MAX_VERTICES = 128,
   parameter int MAX_EDGES    = 1024,
   parameter int MAX_DEGREE   = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [scsr_pkg::OP_W-1:0]      req_op,
   input  logic [scsr_pkg::VTX_W-1:0]     req_first_vertex,
   input  logic [scsr_pkg::VTX_W-1:0]     req_second_vertex,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_done_ok,
   output logic [scsr_pkg::STS_W-1:0]     rsp_status,
   output logic [scsr_pkg::CNT_W-1:0]     rsp_neighbor_count,
   output logic [scsr_pkg::VTX_W-1:0]     rsp_neighbor,
   output logic                           rsp_list_empty,
   output logic                           rsp_last,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [scsr_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [scsr_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [scsr_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                           csr_pready
);

   localparam int VW = $clog2(MAX_VERTICES);      // stored neighbour
   localparam int CW = $clog2(MAX_VERTICES + 1);  // vertex count / row-start address
   localparam int KW = CW + 1;                    // row sweep, may pass the count
   localparam int AW = $clog2(MAX_EDGES);         // neighbour store address
   localparam int PW = $clog2(MAX_EDGES + 1);     // entry position / row start value
   localparam int SW = 52;

   typedef enum logic [SW-1:0] {
      S_IDLE = SW'(1) << 0,  S_RESP = SW'(1) << 1,  S_CLR  = SW'(1) << 2,
      S_F0   = SW'(1) << 3,  S_F1   = SW'(1) << 4,  S_F2   = SW'(1) << 5,
      S_T0   = SW'(1) << 6,  S_T1   = SW'(1) << 7,  S_L0   = SW'(1) << 8,
      S_L1   = SW'(1) << 9,  S_I0   = SW'(1) << 10, S_I1   = SW'(1) << 11,
      S_E0   = SW'(1) << 12, S_E1   = SW'(1) << 13, S_R0   = SW'(1) << 14,
      S_R1   = SW'(1) << 15, S_AD2  = SW'(1) << 16, S_AD3  = SW'(1) << 17,
      S_AD4  = SW'(1) << 18, S_AD5  = SW'(1) << 19, S_AD7  = SW'(1) << 20,
      S_DS2  = SW'(1) << 21, S_DS3  = SW'(1) << 22, S_DL1  = SW'(1) << 23,
      S_DL2  = SW'(1) << 24, S_TS2  = SW'(1) << 25, S_DG   = SW'(1) << 26,
      S_LS0  = SW'(1) << 27, S_LS1  = SW'(1) << 28, S_LS2  = SW'(1) << 29,
      S_CL0  = SW'(1) << 30, S_CL1  = SW'(1) << 31, S_CL2  = SW'(1) << 32,
      S_CL3  = SW'(1) << 33, S_CL4  = SW'(1) << 34, S_CL5  = SW'(1) << 35,
      S_CL6  = SW'(1) << 36, S_RM0  = SW'(1) << 37, S_MV0  = SW'(1) << 38,
      S_MV1  = SW'(1) << 39, S_MV2  = SW'(1) << 40, S_MV3  = SW'(1) << 41,
      S_B0   = SW'(1) << 42, S_B1   = SW'(1) << 43, S_MB1  = SW'(1) << 44,
      S_MB2  = SW'(1) << 45, S_MB3  = SW'(1) << 46, S_MB4  = SW'(1) << 47,
      S_MB5  = SW'(1) << 48, S_MVF  = SW'(1) << 49, S_OKN  = SW'(1) << 50,
      S_OKD  = SW'(1) << 51
   } state_type;

   // sequencer state and return points
   state_type state_ff, state_in;
   state_type ret_ff, ret_in;    // after a row fetch, count read or shift
   state_type sret_ff, sret_in;  // after a row scan
   state_type dret_ff, dret_in;  // after a one-sided delete

   scsr_pkg::op_type  op_ff, op_in;
   scsr_pkg::rsp_type rsp_ff, rsp_in;

   logic [scsr_pkg::CFG_W-1:0] ivc_ff, ivc_in;
   logic [CW-1:0] live_ff, live_in;
   logic [VW-1:0] a_ff, a_in, b_ff, b_in, t_ff, t_in, h_ff, h_in;
   logic [CW-1:0] u_ff, u_in, mu_ff, mu_in;
   logic [KW-1:0] k_ff, k_in;
   logic [PW-1:0] beg_ff, beg_in, end_ff, end_in, p_ff, p_in, i_ff, i_in;
   logic [PW-1:0] pos_ff, pos_in, tot_ff, tot_in, amt_ff, amt_in;
   logic [PW-1:0] lp_ff, lp_in, lim_ff, lim_in;
   logic [PW-1:0] bigp_ff, bigp_in, bigt_ff, bigt_in, rot_ff, rot_in;
   logic locate_ff, locate_in, found_ff, found_in, sub_ff, sub_in, upd_ff, upd_in;
   logic fulla_ff, fulla_in, fullb_ff, fullb_in;

   logic [PW-1:0] deg;
   logic          range_bad, add_full;

   // neighbour store and row starts, one read and one write port each, registered reads
   logic [VW-1:0] nbr_mem [MAX_EDGES];
   logic [PW-1:0] rs_mem  [MAX_VERTICES + 1];
   logic [VW-1:0] nbr_rd_ff;
   logic [PW-1:0] rs_rd_ff;
   logic          nbr_we, rs_we;
   logic [AW-1:0] nbr_raddr, nbr_waddr;
   logic [VW-1:0] nbr_wdata;
   logic [CW-1:0] rs_raddr, rs_waddr;
   logic [PW-1:0] rs_wdata;

   always_ff @(posedge clock) begin
      if (nbr_we) begin
         nbr_mem[nbr_waddr] <= nbr_wdata;
      end
      nbr_rd_ff <= nbr_mem[nbr_raddr];
   end

   always_ff @(posedge clock) begin
      if (rs_we) begin
         rs_mem[rs_waddr] <= rs_wdata;
      end
      rs_rd_ff <= rs_mem[rs_raddr];
   end

   // ---------------------------------------------------------------------
   // Handshakes and register port
   // ---------------------------------------------------------------------
   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = (state_ff == S_RESP);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[scsr_pkg::CSR_AW-1:2] == scsr_pkg::REG_IVC) ?
                       scsr_pkg::CSR_DW'(ivc_ff) : '0;

   assign rsp_done_ok        = rsp_ff.done_ok;
   assign rsp_status         = rsp_ff.status;
   assign rsp_neighbor_count = rsp_ff.neighbor_count;
   assign rsp_neighbor       = rsp_ff.neighbor;
   assign rsp_list_empty     = rsp_ff.list_empty;
   assign rsp_last           = rsp_ff.last;

   // degree of the row held in beg/end
   assign deg = PW'(end_ff - beg_ff);

   // the first operand, and the second for add, delete and test, is refused at or above the vertex count
   assign range_bad = (32'(req_first_vertex) >= 32'(live_ff)) ||
                      ((scsr_pkg::op_type'(req_op) == scsr_pkg::OP_ADD ||
                        scsr_pkg::op_type'(req_op) == scsr_pkg::OP_DELETE ||
                        scsr_pkg::op_type'(req_op) == scsr_pkg::OP_TEST) &&
                       (32'(req_second_vertex) >= 32'(live_ff)));

   // a self loop takes one slot, any other edge two
   assign add_full = (32'(tot_ff) + ((a_ff == b_ff) ? 32'd1 : 32'd2) > MAX_EDGES) ||
                     fulla_ff || ((a_ff != b_ff) && fullb_ff);

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;  ret_in  = ret_ff;  sret_in = sret_ff;  dret_in = dret_ff;
      op_in     = op_ff;     rsp_in  = rsp_ff;  ivc_in  = ivc_ff;   live_in = live_ff;
      a_in      = a_ff;      b_in    = b_ff;    t_in    = t_ff;     h_in    = h_ff;
      u_in      = u_ff;      mu_in   = mu_ff;   k_in    = k_ff;
      beg_in    = beg_ff;    end_in  = end_ff;  p_in    = p_ff;     i_in    = i_ff;
      pos_in    = pos_ff;    tot_in  = tot_ff;  amt_in  = amt_ff;
      lp_in     = lp_ff;     lim_in  = lim_ff;
      bigp_in   = bigp_ff;   bigt_in = bigt_ff; rot_in  = rot_ff;
      locate_in = locate_ff; found_in = found_ff; sub_in = sub_ff;  upd_in  = upd_ff;
      fulla_in  = fulla_ff;  fullb_in = fullb_ff;
      nbr_we    = 1'b0;      nbr_waddr = '0;    nbr_wdata = '0;     nbr_raddr = '0;
      rs_we     = 1'b0;      rs_waddr  = '0;    rs_wdata  = '0;     rs_raddr  = '0;

      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          csr_paddr[scsr_pkg::CSR_AW-1:2] == scsr_pkg::REG_IVC) begin
         ivc_in = csr_pwdata[scsr_pkg::CFG_W-1:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = scsr_pkg::op_type'(req_op);
               a_in  = VW'(req_first_vertex);
               b_in  = VW'(req_second_vertex);
               u_in  = CW'(req_first_vertex);
               if (scsr_pkg::op_type'(req_op) == scsr_pkg::OP_REBUILD) begin
                  // saturate the starting count, then clear every row start
                  live_in  = (32'(ivc_ff) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(ivc_ff);
                  k_in     = '0;
                  state_in = S_CLR;
               end else if (range_bad) begin
                  rsp_in   = scsr_pkg::mk_rsp(1'b0, scsr_pkg::STS_RANGE);
                  state_in = S_RESP;
               end else begin
                  state_in = S_F0;
                  case (scsr_pkg::op_type'(req_op))
                     scsr_pkg::OP_ADD: begin
                        t_in = VW'(req_second_vertex); locate_in = 1'b1;
                        ret_in = S_L0; sret_in = S_AD2;
                     end
                     scsr_pkg::OP_DELETE: begin
                        t_in = VW'(req_second_vertex); locate_in = 1'b0;
                        ret_in = S_L0; sret_in = S_DS2; dret_in = S_DL1;
                     end
                     scsr_pkg::OP_TEST: begin
                        t_in = VW'(req_second_vertex); locate_in = 1'b1;
                        ret_in = S_L0; sret_in = S_TS2;
                     end
                     scsr_pkg::OP_DEGREE: ret_in = S_DG;
                     scsr_pkg::OP_LIST:   ret_in = S_LS0;
                     scsr_pkg::OP_CLEAR:  ret_in = S_CL0;
                     default:             ret_in = S_RM0;
                  endcase
               end
            end
         end

         S_RESP: begin
            if (rsp_ready) begin
               if (op_ff == scsr_pkg::OP_LIST && !rsp_ff.last) begin
                  lp_in    = PW'(lp_ff + 1'b1);
                  p_in     = PW'(p_ff + 1'b1);
                  state_in = S_LS1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         S_CLR: begin
            rs_we    = 1'b1;
            rs_waddr = k_ff[CW-1:0];
            if (32'(k_ff) == MAX_VERTICES) begin
               state_in = S_OKN;
            end else begin
               k_in = KW'(k_ff + 1'b1);
            end
         end

         // fetch the bounds of row u
         S_F0: begin
            rs_raddr = u_ff;
            state_in = S_F1;
         end
         S_F1: begin
            beg_in   = rs_rd_ff;
            rs_raddr = CW'(u_ff + 1'b1);
            state_in = S_F2;
         end
         S_F2: begin
            end_in   = rs_rd_ff;
            p_in     = beg_ff;
            state_in = ret_ff;
         end

         // read the entry count
         S_T0: begin
            rs_raddr = live_ff;
            state_in = S_T1;
         end
         S_T1: begin
            tot_in   = rs_rd_ff;
            state_in = ret_ff;
         end

         // scan the row: stop at the first entry >= t, or at t itself
         S_L0: begin
            if (p_ff == end_ff) begin
               found_in = 1'b0;
               state_in = sret_ff;
            end else begin
               nbr_raddr = p_ff[AW-1:0];
               state_in  = S_L1;
            end
         end
         S_L1: begin
            if (locate_ff ? (nbr_rd_ff >= t_ff) : (nbr_rd_ff == t_ff)) begin
               found_in = (nbr_rd_ff == t_ff);
               state_in = sret_ff;
            end else begin
               p_in     = PW'(p_ff + 1'b1);
               state_in = S_L0;
            end
         end

         // open a hole at pos by moving entries up, top first, then drop t in
         S_I0: begin
            if (i_ff == pos_ff) begin
               nbr_we    = 1'b1;
               nbr_waddr = pos_ff[AW-1:0];
               nbr_wdata = t_ff;
               k_in      = KW'(u_ff) + 1'b1;
               state_in  = upd_ff ? S_R0 : ret_ff;
            end else begin
               nbr_raddr = AW'(i_ff - 1'b1);
               state_in  = S_I1;
            end
         end
         S_I1: begin
            nbr_we    = 1'b1;
            nbr_waddr = i_ff[AW-1:0];
            nbr_wdata = nbr_rd_ff;
            i_in      = PW'(i_ff - 1'b1);
            state_in  = S_I0;
         end

         // close a gap of amt entries at i by moving the tail down
         S_E0: begin
            if (PW'(i_ff + amt_ff) == tot_ff) begin
               k_in     = KW'(u_ff) + 1'b1;
               state_in = S_R0;
            end else begin
               nbr_raddr = AW'(i_ff + amt_ff);
               state_in  = S_E1;
            end
         end
         S_E1: begin
            nbr_we    = 1'b1;
            nbr_waddr = i_ff[AW-1:0];
            nbr_wdata = nbr_rd_ff;
            i_in      = PW'(i_ff + 1'b1);
            state_in  = S_E0;
         end

         // shift the row starts above row u by amt
         S_R0: begin
            if (32'(k_ff) > 32'(live_ff)) begin
               state_in = ret_ff;
            end else begin
               rs_raddr = k_ff[CW-1:0];
               state_in = S_R1;
            end
         end
         S_R1: begin
            rs_we    = 1'b1;
            rs_waddr = k_ff[CW-1:0];
            rs_wdata = sub_ff ? PW'(rs_rd_ff - amt_ff) : PW'(rs_rd_ff + amt_ff);
            k_in     = KW'(k_ff + 1'b1);
            state_in = S_R0;
         end

         // add edge
         S_AD2: begin
            if (found_ff) begin
               rsp_in   = scsr_pkg::mk_rsp(1'b0, scsr_pkg::STS_MISS);
               state_in = S_RESP;
            end else begin
               pos_in   = p_ff;
               fulla_in = (32'(deg) >= MAX_DEGREE);
               u_in     = CW'(b_ff);
               ret_in   = S_AD3;
               state_in = S_F0;
            end
         end
         S_AD3: begin
            fullb_in = (32'(deg) >= MAX_DEGREE);
            ret_in   = S_AD4;
            state_in = S_T0;
         end
         S_AD4: begin
            if (add_full) begin
               rsp_in   = scsr_pkg::mk_rsp(1'b0, scsr_pkg::STS_FULL);
               state_in = S_RESP;
            end else begin
               u_in   = CW'(a_ff);
               t_in   = b_ff;
               i_in   = tot_ff;
               tot_in = PW'(tot_ff + 1'b1);
               amt_in = PW'(1);
               sub_in = 1'b0;
               upd_in = 1'b1;
               ret_in = S_AD5;
               state_in = S_I0;
            end
         end
         S_AD5: begin
            u_in      = CW'(b_ff);
            t_in      = a_ff;
            locate_in = 1'b1;
            ret_in    = S_L0;
            sret_in   = S_AD7;
            state_in  = S_F0;
         end
         S_AD7: begin
            if (found_ff) begin
               // self loop: the first side already holds it
               rsp_in   = scsr_pkg::mk_rsp(1'b0, scsr_pkg::STS_MISS);
               state_in = S_RESP;
            end else begin
               pos_in   = p_ff;
               i_in     = tot_ff;
               ret_in   = S_OKD;
               state_in = S_I0;
            end
         end

         // one-sided delete of t from row u, back to dret
         S_DS2: begin
            if (!found_ff) begin
               state_in = dret_ff;
            end else begin
               ret_in   = S_DS3;
               state_in = S_T0;
            end
         end
         S_DS3: begin
            i_in     = p_ff;
            amt_in   = PW'(1);
            sub_in   = 1'b1;
            upd_in   = 1'b1;
            ret_in   = dret_ff;
            state_in = S_E0;
         end

         // delete edge: stop after a failed first side
         S_DL1: begin
            if (!found_ff) begin
               rsp_in   = scsr_pkg::mk_rsp(1'b0, scsr_pkg::STS_MISS);
               state_in = S_RESP;
            end else begin
               u_in      = CW'(b_ff);
               t_in      = a_ff;
               locate_in = 1'b0;
               ret_in    = S_L0;
               sret_in   = S_DS2;
               dret_in   = S_DL2;
               state_in  = S_F0;
            end
         end
         S_DL2: begin
            state_in = found_ff ? S_OKD : S_RESP;
            if (!found_ff) begin
               rsp_in = scsr_pkg::mk_rsp(1'b0, scsr_pkg::STS_MISS);
            end
         end

         S_TS2: begin
            state_in = found_ff ? S_OKD : S_RESP;
            if (!found_ff) begin
               rsp_in = scsr_pkg::mk_rsp(1'b0, scsr_pkg::STS_MISS);
            end
         end

         S_DG: begin
            rsp_in                = scsr_pkg::mk_rsp(1'b0, scsr_pkg::STS_OK);
            rsp_in.neighbor_count = scsr_pkg::CNT_W'(deg);
            state_in              = S_RESP;
         end

         // list neighbours, one beat each
         S_LS0: begin
            if (deg == '0) begin
               rsp_in            = scsr_pkg::mk_rsp(1'b0, scsr_pkg::STS_OK);
               rsp_in.list_empty = 1'b1;
               state_in          = S_RESP;
            end else begin
               lim_in   = (32'(deg) > scsr_pkg::RESULT_LIMIT) ?
                          PW'(scsr_pkg::RESULT_LIMIT) : deg;
               lp_in    = '0;
               state_in = S_LS1;
            end
         end
         S_LS1: begin
            nbr_raddr = p_ff[AW-1:0];
            state_in  = S_LS2;
         end
         S_LS2: begin
            rsp_in                = scsr_pkg::mk_rsp(1'b0, scsr_pkg::STS_OK);
            rsp_in.neighbor_count = scsr_pkg::CNT_W'(deg);
            rsp_in.neighbor       = scsr_pkg::VTX_W'(nbr_rd_ff);
            rsp_in.last           = (PW'(lp_ff + 1'b1) == lim_ff);
            state_in              = S_RESP;
         end

         // clear vertex: drop a from each neighbour's row, then erase row a
         S_CL0: begin
            lim_in   = deg;
            lp_in    = '0;
            state_in = S_CL1;
         end
         S_CL1: begin
            u_in     = CW'(a_ff);
            ret_in   = (lp_ff == lim_ff) ? S_CL5 : S_CL2;
            state_in = S_F0;
         end
         S_CL2: begin
            nbr_raddr = AW'(beg_ff + lp_ff);
            state_in  = S_CL3;
         end
         S_CL3: begin
            if (nbr_rd_ff != a_ff && 32'(nbr_rd_ff) < 32'(live_ff)) begin
               u_in      = CW'(nbr_rd_ff);
               t_in      = a_ff;
               locate_in = 1'b0;
               ret_in    = S_L0;
               sret_in   = S_DS2;
               dret_in   = S_CL4;
               state_in  = S_F0;
            end else begin
               state_in = S_CL4;
            end
         end
         S_CL4: begin
            lp_in    = PW'(lp_ff + 1'b1);
            state_in = S_CL1;
         end
         S_CL5: begin
            if (deg == '0) begin
               state_in = S_OKN;
            end else begin
               ret_in   = S_CL6;
               state_in = S_T0;
            end
         end
         S_CL6: begin
            i_in     = beg_ff;
            amt_in   = deg;
            sub_in   = 1'b1;
            upd_in   = 1'b1;
            ret_in   = S_OKN;
            state_in = S_E0;
         end

         // remove vertex: only an empty row may go
         S_RM0: begin
            if (deg != '0) begin
               rsp_in   = scsr_pkg::mk_rsp(1'b0, scsr_pkg::STS_MISS);
               state_in = S_RESP;
            end else if (32'(a_ff) + 1 == 32'(live_ff)) begin
               live_in  = CW'(live_ff - 1'b1);
               state_in = S_OKN;
            end else begin
               h_in     = VW'(live_ff - 1'b1);
               mu_in    = '0;
               state_in = S_MV0;
            end
         end
         // relabel h as a in every row; h is always a row's last entry
         S_MV0: begin
            u_in     = (32'(mu_ff) > 32'(h_ff)) ? CW'(a_ff) : mu_ff;
            ret_in   = (32'(mu_ff) > 32'(h_ff)) ? S_MB1 : S_MV1;
            state_in = S_F0;
         end
         S_MV1: begin
            if (deg == '0) begin
               state_in = S_MV3;
            end else begin
               nbr_raddr = AW'(end_ff - 1'b1);
               state_in  = S_MV2;
            end
         end
         S_MV2: begin
            if (nbr_rd_ff == h_ff) begin
               i_in     = PW'(end_ff - 1'b1);
               state_in = S_B0;
            end else begin
               state_in = S_MV3;
            end
         end
         S_MV3: begin
            mu_in    = CW'(mu_ff + 1'b1);
            state_in = S_MV0;
         end
         // sink the new label into place
         S_B0: begin
            if (i_ff == beg_ff) begin
               nbr_we    = 1'b1;
               nbr_waddr = i_ff[AW-1:0];
               nbr_wdata = a_ff;
               state_in  = S_MV3;
            end else begin
               nbr_raddr = AW'(i_ff - 1'b1);
               state_in  = S_B1;
            end
         end
         S_B1: begin
            nbr_we    = 1'b1;
            nbr_waddr = i_ff[AW-1:0];
            if (nbr_rd_ff > a_ff) begin
               nbr_wdata = nbr_rd_ff;
               i_in      = PW'(i_ff - 1'b1);
               state_in  = S_B0;
            end else begin
               nbr_wdata = a_ff;
               state_in  = S_MV3;
            end
         end
         // rotate row h's block down into the empty slot of a
         S_MB1: begin
            bigp_in  = beg_ff;
            u_in     = CW'(h_ff);
            ret_in   = S_MB2;
            state_in = S_F0;
         end
         S_MB2: begin
            bigt_in  = end_ff;
            amt_in   = deg;
            rot_in   = deg;
            state_in = (deg == '0) ? S_MVF : S_MB3;
         end
         S_MB3: begin
            if (rot_ff == '0) begin
               u_in     = CW'(a_ff);
               k_in     = KW'(a_ff) + 1'b1;
               sub_in   = 1'b0;
               ret_in   = S_MVF;
               state_in = S_R0;
            end else begin
               nbr_raddr = AW'(bigt_ff - 1'b1);
               state_in  = S_MB4;
            end
         end
         S_MB4: begin
            t_in     = nbr_rd_ff;
            i_in     = PW'(bigt_ff - 1'b1);
            pos_in   = bigp_ff;
            upd_in   = 1'b0;
            ret_in   = S_MB5;
            state_in = S_I0;
         end
         S_MB5: begin
            rot_in   = PW'(rot_ff - 1'b1);
            state_in = S_MB3;
         end
         S_MVF: begin
            live_in  = CW'(live_ff - 1'b1);
            state_in = S_OKN;
         end

         S_OKN: begin
            rsp_in   = scsr_pkg::mk_rsp(1'b0, scsr_pkg::STS_OK);
            state_in = S_RESP;
         end
         S_OKD: begin
            rsp_in   = scsr_pkg::mk_rsp(1'b1, scsr_pkg::STS_OK);
            state_in = S_RESP;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         live_ff  <= '0;
         ivc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         live_ff  <= live_in;
         ivc_ff   <= ivc_in;
      end
   end

   // working registers, no reset
   always_ff @(posedge clock) begin
      ret_ff    <= ret_in;    sret_ff  <= sret_in;  dret_ff <= dret_in;
      op_ff     <= op_in;     rsp_ff   <= rsp_in;
      a_ff      <= a_in;      b_ff     <= b_in;     t_ff    <= t_in;    h_ff <= h_in;
      u_ff      <= u_in;      mu_ff    <= mu_in;    k_ff    <= k_in;
      beg_ff    <= beg_in;    end_ff   <= end_in;   p_ff    <= p_in;    i_ff <= i_in;
      pos_ff    <= pos_in;    tot_ff   <= tot_in;   amt_ff  <= amt_in;
      lp_ff     <= lp_in;     lim_ff   <= lim_in;
      bigp_ff   <= bigp_in;   bigt_ff  <= bigt_in;  rot_ff  <= rot_in;
      locate_ff <= locate_in; found_ff <= found_in; sub_ff  <= sub_in;  upd_ff <= upd_in;
      fulla_ff  <= fulla_in;  fullb_ff <= fullb_in;
   end

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result beat is pending");

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      32'(live_ff) <= MAX_VERTICES)
      else $error("vertex count above bound");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready)
      else $error("block not free after closing beat");

endmodule

FILE: tb/sorted_csr_adjacency_store_test.sv
// Self-checking testbench for the compressed-row adjacency store: directed and random graph edits.
module sorted_csr_adjacency_store_test;
   timeunit 1ns;
   timeprecision 1ps;
   import scsr_pkg::*;

   localparam int NV        = 128;
   localparam int NE        = 1024;
   localparam int ND        = 32;
   localparam int CYCLE_CAP = 20_000_000;
   localparam int SETTLE    = 400;

   // Mirror of the graph: sorted rows, row starts and live count.  Each
   // accepted request is folded in at once and its beats are queued.
   class adjacency_board;
      logic [VTX_W-1:0] nbr_mem [NE];
      int unsigned      row_at [NV+1];
      int unsigned      live_count;
      int unsigned      rebuild_count;
      rsp_type          beats_due [$];
      int               mismatches;

      function new();
         foreach (row_at[i]) row_at[i] = 0;
         live_count    = 0;
         rebuild_count = 0;
         mismatches    = 0;
      endfunction

      function int unsigned degree(int unsigned u);
         return row_at[u+1] - row_at[u];
      endfunction

      function bit find_slot(int unsigned u, int unsigned t, output int unsigned pos);
         int unsigned p;
         p = row_at[u];
         while (p != row_at[u+1] && nbr_mem[p] < t) p++;
         pos = p;
         return p != row_at[u+1] && nbr_mem[p] == t;
      endfunction

      function void insert_entry(int unsigned u, int unsigned pos, int unsigned t);
         int unsigned total;
         total = row_at[live_count];
         for (int unsigned i = total; i > pos; i--) nbr_mem[i] = nbr_mem[i-1];
         nbr_mem[pos] = t[VTX_W-1:0];
         for (int unsigned i = u + 1; i <= live_count; i++) row_at[i]++;
      endfunction

      function void erase_entries(int unsigned u, int unsigned pos, int unsigned n);
         int unsigned total;
         total = row_at[live_count];
         for (int unsigned i = pos; i + n < total; i++) nbr_mem[i] = nbr_mem[i+n];
         for (int unsigned i = u + 1; i <= live_count; i++) row_at[i] -= n;
      endfunction

      function bit drop_one_side(int unsigned u, int unsigned t);
         for (int unsigned p = row_at[u]; p != row_at[u+1]; p++)
            if (nbr_mem[p] == t) begin
               erase_entries(u, p, 1);
               return 1'b1;
            end
         return 1'b0;
      endfunction

      // move the highest vertex into slot v, relabel and re-sort every row
      function void fold_highest_into(int unsigned v);
         logic [VTX_W-1:0] tmp_mem [NE];
         int unsigned      tmp_row [NV+1];
         int unsigned      h, pos, base, src, j;
         logic [VTX_W-1:0] x;
         h   = live_count - 1;
         pos = 0;
         for (int unsigned u = 0; u < h; u++) begin
            src        = (u == v) ? h : u;
            base       = pos;
            tmp_row[u] = pos;
            for (int unsigned p = row_at[src]; p != row_at[src+1]; p++) begin
               x              = nbr_mem[p];
               tmp_mem[pos++] = (x == h) ? v[VTX_W-1:0] : x;
            end
            for (int unsigned i = base + 1; i < pos; i++) begin
               x = tmp_mem[i];
               j = i;
               while (j > base && tmp_mem[j-1] > x) begin
                  tmp_mem[j] = tmp_mem[j-1];
                  j--;
               end
               tmp_mem[j] = x;
            end
         end
         tmp_row[h] = pos;
         for (int unsigned i = 0; i < pos; i++) nbr_mem[i] = tmp_mem[i];
         for (int unsigned i = 0; i <= h; i++) row_at[i] = tmp_row[i];
      endfunction

      function void push_beat(bit ok, sts_type st, int unsigned cnt, int unsigned nb,
                              bit empty, bit fin);
         rsp_type r;
         r.done_ok        = ok;
         r.status         = st;
         r.neighbor_count = cnt[CNT_W-1:0];
         r.neighbor       = nb[VTX_W-1:0];
         r.list_empty     = empty;
         r.last           = fin;
         beats_due.push_back(r);
      endfunction

      function void note_request(op_type op, int unsigned a, int unsigned b);
         int unsigned      live, pos, n, cnt;
         logic [VTX_W-1:0] kept [$];
         live = live_count;
         if (op == OP_REBUILD) begin
            live_count = (rebuild_count > NV) ? NV : rebuild_count;
            foreach (row_at[i]) row_at[i] = 0;
            push_beat(0, STS_OK, 0, 0, 0, 1);
            return;
         end
         if (a >= live || (op inside {OP_ADD, OP_DELETE, OP_TEST} && b >= live)) begin
            push_beat(0, STS_RANGE, 0, 0, 0, 1);
            return;
         end
         case (op)
            OP_ADD: begin
               if (find_slot(a, b, pos)) begin
                  push_beat(0, STS_MISS, 0, 0, 0, 1);
                  return;
               end
               n = (a == b) ? 1 : 2;
               if (row_at[live] + n > NE || degree(a) >= ND ||
                   (a != b && degree(b) >= ND)) begin
                  push_beat(0, STS_FULL, 0, 0, 0, 1);
                  return;
               end
               insert_entry(a, pos, b);
               // a self loop finds its own entry on the second side
               if (find_slot(b, a, pos)) begin
                  push_beat(0, STS_MISS, 0, 0, 0, 1);
                  return;
               end
               insert_entry(b, pos, a);
               push_beat(1, STS_OK, 0, 0, 0, 1);
            end
            OP_DELETE: begin
               if (drop_one_side(a, b) && drop_one_side(b, a))
                  push_beat(1, STS_OK, 0, 0, 0, 1);
               else
                  push_beat(0, STS_MISS, 0, 0, 0, 1);
            end
            OP_TEST: begin
               if (find_slot(a, b, pos)) push_beat(1, STS_OK, 0, 0, 0, 1);
               else                      push_beat(0, STS_MISS, 0, 0, 0, 1);
            end
            OP_DEGREE: push_beat(0, STS_OK, degree(a), 0, 0, 1);
            OP_LIST: begin
               n = degree(a);
               if (n == 0) begin
                  push_beat(0, STS_OK, 0, 0, 1, 1);
                  return;
               end
               cnt = (n > RESULT_LIMIT) ? RESULT_LIMIT : n;
               for (int unsigned i = 0; i < cnt; i++)
                  push_beat(0, STS_OK, n, nbr_mem[row_at[a]+i], 0, i + 1 == cnt);
            end
            OP_CLEAR: begin
               for (int unsigned p = row_at[a]; p != row_at[a+1]; p++)
                  kept.push_back(nbr_mem[p]);
               foreach (kept[i])
                  if (kept[i] != a && kept[i] < live) void'(drop_one_side(kept[i], a));
               erase_entries(a, row_at[a], degree(a));
               push_beat(0, STS_OK, 0, 0, 0, 1);
            end
            default: begin
               if (degree(a) != 0) begin
                  push_beat(0, STS_MISS, 0, 0, 0, 1);
                  return;
               end
               if (a != live - 1) fold_highest_into(a);
               live_count = live - 1;
               push_beat(0, STS_OK, 0, 0, 0, 1);
            end
         endcase
      endfunction

      function void check_beat(rsp_type got);
         rsp_type want;
         if (beats_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %p", got);
            return;
         end
         want = beats_due.pop_front();
         if (got.done_ok !== want.done_ok || got.status !== want.status ||
             got.neighbor_count !== want.neighbor_count ||
             got.neighbor !== want.neighbor || got.list_empty !== want.list_empty ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [OP_W-1:0]     req_op;
   logic [VTX_W-1:0]    req_first_vertex;
   logic [VTX_W-1:0]    req_second_vertex;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_done_ok;
   logic [STS_W-1:0]    rsp_status;
   logic [CNT_W-1:0]    rsp_neighbor_count;
   logic [VTX_W-1:0]    rsp_neighbor;
   logic                rsp_list_empty;
   logic                rsp_last;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   adjacency_board graph = new();
   int unsigned    cycle_count;
   int unsigned    idle_pct;

   sorted_csr_adjacency_store u_top (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Result side: stall at random, with the same idling share as the sender.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else       rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   // Check every result beat taken at this edge against the oldest expectation.
   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.done_ok        = rsp_done_ok;
         got.status         = sts_type'(rsp_status);
         got.neighbor_count = rsp_neighbor_count;
         got.neighbor       = rsp_neighbor;
         got.list_empty     = rsp_list_empty;
         got.last           = rsp_last;
         graph.check_beat(got);
      end
   end

   // Offer one request; hold valid across back-to-back beats, drop it only to idle.
   task automatic send(op_type op, int unsigned a, int unsigned b);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_first_vertex  <= a[VTX_W-1:0];
      req_second_vertex <= b[VTX_W-1:0];
      do @(posedge clock); while (!req_ready);
      graph.note_request(op, a, b);
   endtask

   // Drain: wait for every expected beat, then let the sequencer settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (graph.beats_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Write the rebuild vertex count through the register port (setup, then access).
   task automatic set_rebuild_count(int unsigned value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_IVC, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      graph.rebuild_count = value & 8'hFF;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic int unsigned pick_vertex();
      if (graph.live_count == 0 || $urandom_range(99) < 6) return $urandom_range(127);
      return $urandom_range(graph.live_count - 1);
   endfunction

   task automatic random_round(int unsigned count, int unsigned items);
      int unsigned roll;
      set_rebuild_count(count);
      send(OP_REBUILD, $urandom_range(127), $urandom_range(127));
      for (int i = 0; i < items; i++) begin
         roll = $urandom_range(99);
         if      (roll < 38) send(OP_ADD,     pick_vertex(), pick_vertex());
         else if (roll < 52) send(OP_DELETE,  pick_vertex(), pick_vertex());
         else if (roll < 62) send(OP_TEST,    pick_vertex(), pick_vertex());
         else if (roll < 69) send(OP_DEGREE,  pick_vertex(), $urandom_range(127));
         else if (roll < 79) send(OP_LIST,    pick_vertex(), $urandom_range(127));
         else if (roll < 88) send(OP_CLEAR,   pick_vertex(), $urandom_range(127));
         else if (roll < 98) send(OP_REMOVE,  pick_vertex(), $urandom_range(127));
         else                send(OP_REBUILD, pick_vertex(), $urandom_range(127));
      end
      drain();
   endtask

   initial begin
      cycle_count       = 0;
      idle_pct          = 24;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_op            = OP_REBUILD;
      req_first_vertex  = '0;
      req_second_vertex = '0;
      rsp_ready         = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Before any rebuild the graph has no vertices: every operand is out of range.
      send(OP_ADD, 0, 1);
      send(OP_LIST, 0, 0);
      drain();

      // Directed walk on a six-vertex graph.
      set_rebuild_count(6);
      send(OP_REBUILD, 0, 0);
      send(OP_ADD, 0, 1);
      send(OP_ADD, 1, 0);             // duplicate from the other side
      send(OP_ADD, 0, 3);
      send(OP_ADD, 2, 2);             // self loop
      send(OP_ADD, 0, 5);
      send(OP_TEST, 1, 0);
      send(OP_TEST, 3, 4);
      send(OP_DEGREE, 0, 0);
      send(OP_LIST, 0, 0);
      send(OP_LIST, 4, 0);            // empty list
      send(OP_DELETE, 2, 2);          // self loop delete
      send(OP_DELETE, 1, 4);          // absent edge
      send(OP_DELETE, 0, 1);
      send(OP_ADD, 6, 0);             // first operand out of range
      send(OP_TEST, 0, 127);          // second operand out of range
      send(OP_CLEAR, 0, 0);
      send(OP_ADD, 4, 5);
      send(OP_ADD, 2, 5);
      send(OP_REMOVE, 2, 0);          // still has edges: refused
      send(OP_REMOVE, 1, 0);          // vertex 5 moves into slot 1
      send(OP_LIST, 2, 0);
      send(OP_LIST, 4, 0);
      send(OP_CLEAR, 4, 0);
      send(OP_REMOVE, 4, 0);          // highest vertex
      drain();

      // Degree bound and the longest listing.
      set_rebuild_count(40);
      send(OP_REBUILD, 0, 0);
      for (int i = 1; i <= 33; i++) send(OP_ADD, 0, i);
      send(OP_LIST, 0, 0);
      send(OP_ADD, 34, 0);
      send(OP_DEGREE, 0, 0);
      drain();

      // Fill the store to its last entry with an oversized count; no idling here.
      idle_pct = 0;
      set_rebuild_count(255);
      send(OP_REBUILD, 0, 0);
      for (int k = 1; k <= 4; k++)
         for (int u = 0; u < NV; u++) send(OP_ADD, u, (u + k) % NV);
      send(OP_ADD, 0, 64);            // store full
      send(OP_LIST, 127, 0);
      send(OP_CLEAR, 127, 0);
      send(OP_REMOVE, 127, 0);
      send(OP_CLEAR, 64, 0);
      send(OP_REMOVE, 64, 0);
      send(OP_LIST, 64, 0);
      drain();
      idle_pct = 24;

      // Empty rebuild leaves nothing in range.
      set_rebuild_count(0);
      send(OP_REBUILD, 0, 0);
      send(OP_DEGREE, 0, 0);
      drain();

      // Random rounds on graphs of assorted sizes, one without idling.
      random_round(12, 75);
      random_round(128, 50);
      idle_pct = 0;
      random_round(24, 75);
      idle_pct = 24;
      random_round($urandom_range(2, 40), 75);
      random_round(6, 40);

      drain();
      if (graph.mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
